/* sv/i2cram_pkg.sv */
// Shared types and constants for the I2C register access master.
`default_nettype none
package i2cram_pkg;

  localparam int unsigned ACK_POLL_RESET = 10;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BURST  = 2'd1;
  localparam logic [1:0] OP_SINGLE = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
    PH_RS_A, PH_RS_B, PH_RS_C, PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH,
    PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  typedef enum logic [2:0] {
    ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R, ST_READ
  } stage_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  operation;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [7:0]  write_data;
    logic [7:0]  read_length;
    logic        sda_sample;
  } req_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_enable;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        read_last;
  } res_t;

endpackage
`default_nettype wire

/* sv/i2cram_fifo.sv */
// Small show-ahead register queue used on both sides of the engine.
`default_nettype none
module i2cram_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/i2cram_front.sv */
// Front end: classifies each incoming request and queues it for the engine.
`default_nettype none
module i2cram_front
  import i2cram_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       mode,
  input  wire logic [1:0] operation,
  input  wire logic [6:0] device_address,
  input  wire logic [7:0] register_address,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] read_length,
  input  wire logic       sda_sample,
  output logic            req_valid,
  output req_t            req,
  input  wire logic       req_take
);
  req_t  incoming;
  logic  q_empty;
  logic [$bits(req_t)-1:0] q_rdata;

  // A command with the unused operation code never starts anything.
  always_comb begin
    incoming = '0;
    if (!mode) begin
      incoming.kind = KIND_TICK;
    end else if (operation == OP_WRITE || operation == OP_BURST ||
                 operation == OP_SINGLE) begin
      incoming.kind = KIND_CMD;
    end else begin
      incoming.kind = KIND_NOP;
    end
    incoming.operation        = operation;
    incoming.device_address   = device_address;
    incoming.register_address = register_address;
    incoming.write_data       = write_data;
    incoming.read_length      = (operation == OP_BURST) ? read_length : 8'd1;
    incoming.sda_sample       = sda_sample;
  end

  i2cram_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (incoming),
    .full  (full),
    .pop   (req_take),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign req_valid = !q_empty;
  assign req       = req_t'(q_rdata);
endmodule
`default_nettype wire

/* sv/i2cram_engine.sv */
// Bus engine: runs one half-bit bus phase per tick request and forms a result.
`default_nettype none
module i2cram_engine
  import i2cram_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       take,
  input  wire req_t       req,
  output res_t            res
);
  phase_t     phase, phase_next;
  stage_t     stage, stage_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] poll_count, poll_count_next;
  logic [1:0] held_operation, held_operation_next;
  logic [6:0] held_device, held_device_next;
  logic [7:0] held_register, held_register_next;
  logic [7:0] held_data, held_data_next;
  logic       scl_out, scl_out_next;
  logic       sda_out, sda_out_next;
  logic       abort_flag, abort_flag_next;
  logic [7:0] ack_poll_limit;
  logic       tick;
  logic       acked;

  assign tick  = take && (req.kind == KIND_TICK);
  assign acked = !req.sda_sample;

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    poll_count_next     = poll_count;
    held_operation_next = held_operation;
    held_device_next    = held_device;
    held_register_next  = held_register;
    held_data_next      = held_data;
    scl_out_next        = scl_out;
    sda_out_next        = sda_out;
    abort_flag_next     = abort_flag;
    if (take && req.kind == KIND_CMD && phase == PH_IDLE) begin
      held_operation_next = req.operation;
      held_device_next    = req.device_address;
      held_register_next  = req.register_address;
      held_data_next      = req.write_data;
      bytes_left_next     = req.read_length;
      stage_next          = ST_ADDR_W;
      abort_flag_next     = 1'b0;
      poll_count_next     = '0;
      bit_count_next      = '0;
      shift_byte_next     = {req.device_address, 1'b0};
      phase_next          = PH_START;
    end else if (tick) begin
      unique case (phase)
        PH_START: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b0;
          shift_byte_next = {held_device, 1'b0};
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          scl_out_next    = 1'b0;
          sda_out_next    = shift_byte[7];
          shift_byte_next = {shift_byte[6:0], 1'b0};
          phase_next      = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_out_next   = 1'b1;
          bit_count_next = bit_count + 1'b1;
          phase_next     = (bit_count == 3'd7) ? PH_ACK_LOW : PH_TX_LOW;
        end
        PH_ACK_LOW: begin
          scl_out_next    = 1'b0;
          sda_out_next    = 1'b1;
          poll_count_next = '0;
          phase_next      = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
          if (acked || poll_count >= ack_poll_limit) begin
            // Acknowledge settled: a NACK only aborts where it matters.
            unique case (stage)
              ST_ADDR_W: begin
                if (!acked && held_operation != OP_SINGLE) begin
                  abort_flag_next = 1'b1;
                  phase_next      = PH_STOP_A;
                end else begin
                  stage_next      = ST_REG;
                  shift_byte_next = held_register;
                  bit_count_next  = '0;
                  phase_next      = PH_TX_LOW;
                end
              end
              ST_REG: begin
                if (held_operation == OP_WRITE) begin
                  stage_next      = ST_DATA;
                  shift_byte_next = held_data;
                  bit_count_next  = '0;
                  phase_next      = PH_TX_LOW;
                end else begin
                  stage_next = ST_ADDR_R;
                  phase_next = PH_RS_A;
                end
              end
              ST_DATA: begin
                if (!acked) begin
                  abort_flag_next = 1'b1;
                end
                phase_next = PH_STOP_A;
              end
              default: begin
                stage_next      = ST_READ;
                bit_count_next  = '0;
                shift_byte_next = '0;
                phase_next      = (bytes_left == '0) ? PH_STOP_A : PH_RX_LOW;
              end
            endcase
          end else begin
            poll_count_next = poll_count + 1'b1;
          end
        end
        PH_RS_A: begin
          scl_out_next = 1'b0;
          sda_out_next = 1'b1;
          phase_next   = PH_RS_B;
        end
        PH_RS_B: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
          phase_next   = PH_RS_C;
        end
        PH_RS_C: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b0;
          shift_byte_next = {held_device, 1'b1};
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
        end
        PH_RX_LOW: begin
          scl_out_next = 1'b0;
          sda_out_next = 1'b1;
          phase_next   = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b1;
          shift_byte_next = {shift_byte[6:0], req.sda_sample};
          bit_count_next  = bit_count + 1'b1;
          phase_next      = (bit_count == 3'd7) ? PH_MA_LOW : PH_RX_LOW;
        end
        PH_MA_LOW: begin
          // The master NACKs the last byte and ACKs every other one.
          scl_out_next = 1'b0;
          sda_out_next = (bytes_left == 8'd1);
          phase_next   = PH_MA_HIGH;
        end
        PH_MA_HIGH: begin
          scl_out_next    = 1'b1;
          bytes_left_next = bytes_left - 1'b1;
          shift_byte_next = '0;
          phase_next      = (bytes_left == 8'd1) ? PH_STOP_A : PH_RX_LOW;
        end
        PH_STOP_A: begin
          scl_out_next = 1'b0;
          sda_out_next = 1'b0;
          phase_next   = PH_STOP_B;
        end
        PH_STOP_B: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b0;
          phase_next   = PH_STOP_C;
        end
        PH_STOP_C: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b1;
          abort_flag_next = 1'b0;
          phase_next      = PH_IDLE;
        end
        default: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
          phase_next   = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res            = '0;
    res.scl_level  = scl_out_next;
    res.sda_level  = sda_out_next;
    res.sda_enable = !(phase_next == PH_ACK_LOW || phase_next == PH_ACK_HIGH ||
                       phase_next == PH_RX_LOW || phase_next == PH_RX_HIGH);
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = tick && (phase == PH_STOP_C);
    res.status     = tick && (phase == PH_STOP_C) && abort_flag;
    if (tick && phase == PH_RX_HIGH && bit_count == 3'd7) begin
      res.read_valid = 1'b1;
      res.read_byte  = {shift_byte[6:0], req.sda_sample};
      res.read_last  = (bytes_left == 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_poll_limit <= 8'(ACK_POLL_RESET);
    end else if (cfg_write_en) begin
      ack_poll_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDR_W;
      bit_count      <= '0;
      shift_byte     <= '0;
      bytes_left     <= '0;
      poll_count     <= '0;
      held_operation <= '0;
      held_device    <= '0;
      held_register  <= '0;
      held_data      <= '0;
      scl_out        <= 1'b1;
      sda_out        <= 1'b1;
      abort_flag     <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      poll_count     <= poll_count_next;
      held_operation <= held_operation_next;
      held_device    <= held_device_next;
      held_register  <= held_register_next;
      held_data      <= held_data_next;
      scl_out        <= scl_out_next;
      sda_out        <= sda_out_next;
      abort_flag     <= abort_flag_next;
    end
  end
endmodule
`default_nettype wire

/* sv/i2c_register_access_master_top.sv */
// Each result is formed combinationally and queued at the edge that accepts its request.
// Throughput: one request per cycle unless the result queue is full.
// Request and result queues hold IN_DEPTH and OUT_DEPTH entries, so either side
// may stall without holding up the other until its queue fills.
// Reset (rst, synchronous) empties both queues, returns the bus engine to idle with
// SCL and SDA high, and sets the acknowledge poll limit to 10.
`default_nettype none
module i2c_register_access_master_top
  import i2cram_pkg::*;
#(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic       mode,
  input  wire logic [1:0] operation,
  input  wire logic [6:0] device_address,
  input  wire logic [7:0] register_address,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] read_length,
  input  wire logic       sda_sample,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_level,
  output logic            sda_level,
  output logic            sda_enable,
  output logic            busy_res,
  output logic            done_res,
  output logic            status,
  output logic [7:0]      read_byte,
  output logic            read_valid,
  output logic            read_last
);
  req_t req;
  res_t res;
  res_t res_head;
  logic req_valid;
  logic out_full;
  logic take;
  logic [$bits(res_t)-1:0] out_rdata;

  i2cram_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .mode             (mode),
    .operation        (operation),
    .device_address   (device_address),
    .register_address (register_address),
    .write_data       (write_data),
    .read_length      (read_length),
    .sda_sample       (sda_sample),
    .req_valid        (req_valid),
    .req              (req),
    .req_take         (take)
  );

  assign take = req_valid && !out_full;

  i2cram_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .take           (take),
    .req            (req),
    .res            (res)
  );

  i2cram_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .empty (empty),
    .rdata (out_rdata)
  );

  assign res_head   = res_t'(out_rdata);
  assign scl_level  = res_head.scl_level;
  assign sda_level  = res_head.sda_level;
  assign sda_enable = res_head.sda_enable;
  assign busy_res   = res_head.busy_res;
  assign done_res   = res_head.done_res;
  assign status     = res_head.status;
  assign read_byte  = res_head.read_byte;
  assign read_valid = res_head.read_valid;
  assign read_last  = res_head.read_last;
endmodule
`default_nettype wire

/* sv/i2cram_checker.sv */
// Port-level checker for the I2C register access master, bound to the top level.
`default_nettype none
module i2cram_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       scl_level,
  input wire logic       sda_level,
  input wire logic       sda_enable,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic       status,
  input wire logic [7:0] read_byte,
  input wire logic       read_valid,
  input wire logic       read_last
);
  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A finished transaction leaves the bus idle with both lines high.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> (scl_level && sda_level && !busy_res))
    else $error("done shown without a stop condition");

  a_status_at_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> done_res)
    else $error("status set outside a done request");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !read_valid) |-> (read_byte == 8'd0 && !read_last))
    else $error("read fields set without a completed byte");

  // Whenever SDA is released the master must be in the middle of a transaction.
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && !sda_enable) |-> busy_res)
    else $error("SDA released outside a transaction");
endmodule

bind i2c_register_access_master_top i2cram_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .scl_level  (scl_level),
  .sda_level  (sda_level),
  .sda_enable (sda_enable),
  .busy_res   (busy_res),
  .done_res   (done_res),
  .status     (status),
  .read_byte  (read_byte),
  .read_valid (read_valid),
  .read_last  (read_last)
);
`default_nettype wire
